[sv/tmef_pkg.sv]
// shared types, constants and helpers for the triangle mesh edge flip block
// no dependencies; every other file but tmef_ram imports this package
package tmef_pkg;

  // payload widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned FACE_W   = 10;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned VERT_W   = 10;
  localparam int unsigned NBR_W    = 11;
  localparam int unsigned NSLOT_W  = 3;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned MAX_FACES_DEF = 1024;

  // stored slot code for "no neighbor edge"
  localparam logic [SLOT_W-1:0] SLOT_NONE = 2'd3;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLIP  = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_BOUNDARY = 2'd1,
    ST_INVALID  = 2'd2
  } status_e;

  // microcode fields
  typedef enum logic [1:0] {
    MEM_IDLE,
    MEM_RD,
    MEM_WR
  } mem_op_e;

  // entry address sources: face and slot pairs
  typedef enum logic [3:0] {
    A_00,
    A_01,
    A_02,
    A_10,
    A_11,
    A_12,
    A_X11_T1,
    A_X01_T2,
    A_X11_SX,
    A_X01_SX
  } asel_e;

  // write data sources
  typedef enum logic [3:0] {
    DS_VIN,
    DS_NIN,
    DS_SIN,
    DS_V12,
    DS_V02,
    DS_F0,
    DS_F1,
    DS_F01,
    DS_F11,
    DS_T1,
    DS_T2,
    DS_E0,
    DS_E1,
    DS_E01,
    DS_E11
  } dsel_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_DISPATCH,
    J_BOUNDARY
  } jmp_e;

  localparam int unsigned STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // program layout
  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_WR      = 5'd1;
  localparam step_t S_RD      = 5'd2;
  localparam step_t S_RD_DONE = 5'd3;
  localparam step_t S_ERR     = 5'd4;
  localparam step_t S_BND     = 5'd5;
  localparam step_t S_OK      = 5'd6;
  localparam step_t S_F0      = 5'd7;
  localparam step_t S_F1      = 5'd8;
  localparam step_t S_F2      = 5'd9;
  localparam step_t S_F3      = 5'd10;
  localparam step_t S_F4      = 5'd11;
  localparam step_t S_F5      = 5'd12;
  localparam step_t S_F6      = 5'd13;
  localparam step_t S_F7      = 5'd14;
  localparam step_t S_F8      = 5'd15;
  localparam step_t S_F9      = 5'd16;
  localparam step_t S_F10     = 5'd17;
  localparam step_t S_F11     = 5'd18;
  localparam step_t S_F12     = 5'd19;
  localparam step_t S_F13     = 5'd20;
  localparam step_t S_F14     = 5'd21;

  // register loads from the table read ports
  typedef struct packed {
    logic f1;
    logic e1;
    logic f01;
    logic f11;
    logic v12;
    logic v02;
    logic t1;
    logic t2;
    logic sx;
  } ld_t;

  typedef struct packed {
    mem_op_e cv_op;
    asel_e   cv_a;
    dsel_e   cv_d;
    mem_op_e nf_op;
    asel_e   nf_a;
    dsel_e   nf_d;
    mem_op_e ns_op;
    asel_e   ns_a;
    dsel_e   ns_d;
    ld_t     ld;
    jmp_e    jmp;
    step_t   target;
    logic    done;
    status_e status;
    logic    rd_out;
  } ctl_t;

  // condition inputs to the sequencer
  typedef struct packed {
    logic             accept;
    logic [REQ_W-1:0] req_type;
    logic             addr_bad;
    logic             boundary;
    logic             out_free;
  } seq_in_t;

  function automatic logic [SLOT_W-1:0] slot_inc1(logic [SLOT_W-1:0] e);
    return (e == 2'd2) ? 2'd0 : e + 2'd1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc2(logic [SLOT_W-1:0] e);
    return (e == 2'd0) ? 2'd2 : e - 2'd1;
  endfunction

  // non-negative and below the face count
  function automatic logic face_ok(logic [NBR_W-1:0] f, int unsigned max_faces);
    return !f[NBR_W-1] && (32'(f[NBR_W-2:0]) < max_faces);
  endfunction

endpackage

[sv/tmef_req_if.sv]
// request channel: valid/ready handshake plus one request word
// depends on tmef_pkg for the field widths
interface tmef_req_if;
  import tmef_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [FACE_W-1:0]         face;
  logic [SLOT_W-1:0]         edge_req;
  logic [VERT_W-1:0]         vertex_in;
  logic signed [NBR_W-1:0]   neighbor_in;
  logic signed [NSLOT_W-1:0] neighbor_edge_in;

  modport source (
    output valid, req_type, face, edge_req, vertex_in, neighbor_in, neighbor_edge_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, face, edge_req, vertex_in, neighbor_in, neighbor_edge_in,
    output ready
  );
endinterface

[sv/tmef_rsp_if.sv]
// response channel: valid/ready handshake plus one result word
// depends on tmef_pkg for the field widths
interface tmef_rsp_if;
  import tmef_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [VERT_W-1:0]         vertex_out;
  logic signed [NBR_W-1:0]   neighbor_out;
  logic signed [NSLOT_W-1:0] neighbor_edge_out;
  logic [STATUS_W-1:0]       status;

  modport source (
    output valid, vertex_out, neighbor_out, neighbor_edge_out, status,
    input  ready
  );

  modport sink (
    input  valid, vertex_out, neighbor_out, neighbor_edge_out, status,
    output ready
  );
endinterface

[sv/tmef_ram.sv]
// generic single-port ram, one read or write per cycle, registered read data
// no dependencies
module tmef_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     re_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[sv/tmef_seq.sv]
// microcode sequencer: step counter, control store and jump logic
// depends on tmef_pkg for the control word and step layout
module tmef_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tmef_pkg::seq_in_t seq_i,
  output tmef_pkg::ctl_t    ctl_o
);
  import tmef_pkg::*;

  step_t pc_q, pc_d;
  step_t disp;
  ctl_t  ctl;

  // control store
  function automatic ctl_t rom_word(step_t s);
    ctl_t w;
    w = '0;
    case (s)
      S_IDLE: begin
        w.jmp = J_DISPATCH;
      end
      S_WR: begin
        w.cv_op = MEM_WR; w.cv_a = A_00; w.cv_d = DS_VIN;
        w.nf_op = MEM_WR; w.nf_a = A_00; w.nf_d = DS_NIN;
        w.ns_op = MEM_WR; w.ns_a = A_00; w.ns_d = DS_SIN;
        w.jmp = J_ALWAYS; w.target = S_OK;
      end
      S_RD: begin
        w.cv_op = MEM_RD; w.cv_a = A_00;
        w.nf_op = MEM_RD; w.nf_a = A_00;
        w.ns_op = MEM_RD; w.ns_a = A_00;
      end
      S_RD_DONE: begin
        w.done = 1'b1; w.status = ST_OK; w.rd_out = 1'b1;
        w.jmp = J_ALWAYS; w.target = S_IDLE;
      end
      S_ERR: begin
        w.done = 1'b1; w.status = ST_INVALID;
        w.jmp = J_ALWAYS; w.target = S_IDLE;
      end
      S_BND: begin
        w.done = 1'b1; w.status = ST_BOUNDARY;
        w.jmp = J_ALWAYS; w.target = S_IDLE;
      end
      S_OK: begin
        w.done = 1'b1; w.status = ST_OK;
        w.jmp = J_ALWAYS; w.target = S_IDLE;
      end
      // fetch the neighbor across the flipped edge
      S_F0: begin
        w.nf_op = MEM_RD; w.nf_a = A_00;
        w.ns_op = MEM_RD; w.ns_a = A_00;
      end
      S_F1: begin
        w.ld.f1 = 1'b1; w.ld.e1 = 1'b1;
        w.nf_op = MEM_RD; w.nf_a = A_01;
      end
      S_F2: begin
        w.ld.f01 = 1'b1;
        w.nf_op = MEM_RD; w.nf_a = A_11;
        w.cv_op = MEM_RD; w.cv_a = A_12;
        w.ns_op = MEM_RD; w.ns_a = A_11;
        w.jmp = J_BOUNDARY; w.target = S_BND;
      end
      S_F3: begin
        w.ld.f11 = 1'b1; w.ld.v12 = 1'b1; w.ld.t1 = 1'b1;
        w.cv_op = MEM_RD; w.cv_a = A_02;
        w.ns_op = MEM_RD; w.ns_a = A_01;
      end
      // rewrite corners and inner adjacency
      S_F4: begin
        w.ld.v02 = 1'b1; w.ld.t2 = 1'b1;
        w.cv_op = MEM_WR; w.cv_a = A_01; w.cv_d = DS_V12;
        w.nf_op = MEM_WR; w.nf_a = A_00; w.nf_d = DS_F11;
      end
      S_F5: begin
        w.cv_op = MEM_WR; w.cv_a = A_11; w.cv_d = DS_V02;
        w.nf_op = MEM_WR; w.nf_a = A_01; w.nf_d = DS_F1;
        w.ns_op = MEM_WR; w.ns_a = A_00; w.ns_d = DS_T1;
      end
      S_F6: begin
        w.nf_op = MEM_WR; w.nf_a = A_10; w.nf_d = DS_F01;
        w.ns_op = MEM_WR; w.ns_a = A_10; w.ns_d = DS_T2;
      end
      S_F7: begin
        w.nf_op = MEM_WR; w.nf_a = A_11; w.nf_d = DS_F0;
        w.ns_op = MEM_WR; w.ns_a = A_01; w.ns_d = DS_E11;
      end
      // outer back links, gated in the datapath, plus the last inner slot write
      S_F8: begin
        w.nf_op = MEM_WR; w.nf_a = A_X11_T1; w.nf_d = DS_F0;
        w.ns_op = MEM_WR; w.ns_a = A_11; w.ns_d = DS_E01;
      end
      S_F9: begin
        w.nf_op = MEM_WR; w.nf_a = A_X01_T2; w.nf_d = DS_F1;
        w.ns_op = MEM_RD; w.ns_a = A_00;
      end
      S_F10: begin
        w.ld.sx = 1'b1;
      end
      S_F11: begin
        w.ns_op = MEM_WR; w.ns_a = A_X11_SX; w.ns_d = DS_E0;
      end
      S_F12: begin
        w.ns_op = MEM_RD; w.ns_a = A_10;
      end
      S_F13: begin
        w.ld.sx = 1'b1;
      end
      S_F14: begin
        w.ns_op = MEM_WR; w.ns_a = A_X01_SX; w.ns_d = DS_E1;
        w.jmp = J_ALWAYS; w.target = S_OK;
      end
      default: begin
        w.jmp = J_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  assign ctl = rom_word(pc_q);
  assign ctl_o = ctl;

  // entry point for a new request
  always_comb begin
    disp = S_OK;
    case (seq_i.req_type)
      REQ_WRITE: disp = seq_i.addr_bad ? S_ERR : S_WR;
      REQ_READ:  disp = seq_i.addr_bad ? S_ERR : S_RD;
      REQ_FLIP:  disp = seq_i.addr_bad ? S_ERR : S_F0;
      default:   disp = S_OK;
    endcase
  end

  always_comb begin
    pc_d = pc_q;
    if (ctl.done && !seq_i.out_free) begin
      pc_d = pc_q;
    end else begin
      case (ctl.jmp)
        J_NEXT:     pc_d = pc_q + 1'b1;
        J_ALWAYS:   pc_d = ctl.target;
        J_DISPATCH: pc_d = seq_i.accept ? disp : pc_q;
        J_BOUNDARY: pc_d = seq_i.boundary ? ctl.target : pc_q + 1'b1;
        default:    pc_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end
endmodule

[sv/tmef_dp.sv]
// datapath: request and scratch registers, entry address and data selection,
// and the three mesh tables; depends on tmef_pkg and tmef_ram
module tmef_dp #(
  parameter int unsigned MAX_FACES = tmef_pkg::MAX_FACES_DEF
) (
  input  logic                                    clk_i,
  input  tmef_pkg::ctl_t                          ctl_i,
  input  logic                                    capture_i,
  input  logic [tmef_pkg::FACE_W-1:0]             face_i,
  input  logic [tmef_pkg::SLOT_W-1:0]             edge_i,
  input  logic [tmef_pkg::VERT_W-1:0]             vertex_i,
  input  logic signed [tmef_pkg::NBR_W-1:0]       neighbor_i,
  input  logic signed [tmef_pkg::NSLOT_W-1:0]     neighbor_edge_i,
  output logic                                    boundary_o,
  output logic [tmef_pkg::VERT_W-1:0]             rd_vertex_o,
  output logic signed [tmef_pkg::NBR_W-1:0]       rd_neighbor_o,
  output logic signed [tmef_pkg::NSLOT_W-1:0]     rd_slot_o
);
  import tmef_pkg::*;

  localparam int unsigned ENTRIES = 3 * MAX_FACES;
  localparam int unsigned AW      = $clog2(ENTRIES);

  typedef struct packed {
    logic [FACE_W-1:0] f0;
    logic [SLOT_W-1:0] e0;
    logic [VERT_W-1:0] vin;
    logic [NBR_W-1:0]  nin;
    logic [SLOT_W-1:0] sin;
    logic [NBR_W-1:0]  f1;
    logic [SLOT_W-1:0] e1;
    logic [NBR_W-1:0]  f01;
    logic [NBR_W-1:0]  f11;
    logic [VERT_W-1:0] v12;
    logic [VERT_W-1:0] v02;
    logic [SLOT_W-1:0] t1;
    logic [SLOT_W-1:0] t2;
    logic [SLOT_W-1:0] sx;
  } dp_regs_t;

  dp_regs_t r_q, r_d;

  logic              cv_re, cv_we, nf_re, nf_we, ns_re, ns_we;
  logic [AW-1:0]     cv_addr, nf_addr, ns_addr;
  logic [NBR_W-1:0]  cv_data, nf_data, ns_data;
  logic [VERT_W-1:0] cv_rdata;
  logic [NBR_W-1:0]  nf_rdata;
  logic [SLOT_W-1:0] ns_rdata;

  function automatic logic [FACE_W-1:0] sel_face(asel_e a, dp_regs_t r);
    logic [FACE_W-1:0] f;
    case (a)
      A_00, A_01, A_02:   f = r.f0;
      A_10, A_11, A_12:   f = r.f1[FACE_W-1:0];
      A_X11_T1, A_X11_SX: f = r.f11[FACE_W-1:0];
      A_X01_T2, A_X01_SX: f = r.f01[FACE_W-1:0];
      default:            f = '0;
    endcase
    return f;
  endfunction

  function automatic logic [SLOT_W-1:0] sel_slot(asel_e a, dp_regs_t r);
    logic [SLOT_W-1:0] s;
    case (a)
      A_00:               s = r.e0;
      A_01:               s = slot_inc1(r.e0);
      A_02:               s = slot_inc2(r.e0);
      A_10:               s = r.e1;
      A_11:               s = slot_inc1(r.e1);
      A_12:               s = slot_inc2(r.e1);
      A_X11_T1:           s = r.t1;
      A_X01_T2:           s = r.t2;
      A_X11_SX, A_X01_SX: s = r.sx;
      default:            s = '0;
    endcase
    return s;
  endfunction

  // outer neighbor writes only land on a real face with a real back slot
  function automatic logic sel_gate(asel_e a, dp_regs_t r);
    logic g;
    case (a)
      A_X11_T1: g = face_ok(r.f11, MAX_FACES) && (r.t1 != SLOT_NONE);
      A_X01_T2: g = face_ok(r.f01, MAX_FACES) && (r.t2 != SLOT_NONE);
      A_X11_SX: g = face_ok(r.f11, MAX_FACES) && (r.sx != SLOT_NONE);
      A_X01_SX: g = face_ok(r.f01, MAX_FACES) && (r.sx != SLOT_NONE);
      default:  g = 1'b1;
    endcase
    return g;
  endfunction

  // entry = 3 * face + slot
  function automatic logic [AW-1:0] entry(logic [FACE_W-1:0] f, logic [SLOT_W-1:0] s);
    return AW'({f, 1'b0}) + AW'(f) + AW'(s);
  endfunction

  function automatic logic [NBR_W-1:0] sel_data(dsel_e d, dp_regs_t r);
    logic [NBR_W-1:0] v;
    case (d)
      DS_VIN:  v = {1'b0, r.vin};
      DS_NIN:  v = r.nin;
      DS_SIN:  v = NBR_W'(r.sin);
      DS_V12:  v = {1'b0, r.v12};
      DS_V02:  v = {1'b0, r.v02};
      DS_F0:   v = {1'b0, r.f0};
      DS_F1:   v = r.f1;
      DS_F01:  v = r.f01;
      DS_F11:  v = r.f11;
      DS_T1:   v = NBR_W'(r.t1);
      DS_T2:   v = NBR_W'(r.t2);
      DS_E0:   v = NBR_W'(r.e0);
      DS_E1:   v = NBR_W'(r.e1);
      DS_E01:  v = NBR_W'(slot_inc1(r.e0));
      DS_E11:  v = NBR_W'(slot_inc1(r.e1));
      default: v = '0;
    endcase
    return v;
  endfunction

  // table port controls
  always_comb begin
    cv_addr = entry(sel_face(ctl_i.cv_a, r_q), sel_slot(ctl_i.cv_a, r_q));
    nf_addr = entry(sel_face(ctl_i.nf_a, r_q), sel_slot(ctl_i.nf_a, r_q));
    ns_addr = entry(sel_face(ctl_i.ns_a, r_q), sel_slot(ctl_i.ns_a, r_q));
    cv_re   = (ctl_i.cv_op == MEM_RD);
    nf_re   = (ctl_i.nf_op == MEM_RD);
    ns_re   = (ctl_i.ns_op == MEM_RD);
    cv_we   = (ctl_i.cv_op == MEM_WR) && sel_gate(ctl_i.cv_a, r_q);
    nf_we   = (ctl_i.nf_op == MEM_WR) && sel_gate(ctl_i.nf_a, r_q);
    ns_we   = (ctl_i.ns_op == MEM_WR) && sel_gate(ctl_i.ns_a, r_q);
    cv_data = sel_data(ctl_i.cv_d, r_q);
    nf_data = sel_data(ctl_i.nf_d, r_q);
    ns_data = sel_data(ctl_i.ns_d, r_q);
  end

  // request capture and scratch loads
  always_comb begin
    r_d = r_q;
    if (capture_i) begin
      r_d.f0  = face_i;
      r_d.e0  = edge_i;
      r_d.vin = vertex_i;
      r_d.nin = neighbor_i;
      // neighbor slot outside 0..2 is stored as none
      r_d.sin = (!neighbor_edge_i[NSLOT_W-1] && (neighbor_edge_i[SLOT_W-1:0] != SLOT_NONE))
                ? neighbor_edge_i[SLOT_W-1:0] : SLOT_NONE;
    end
    if (ctl_i.ld.f1)  r_d.f1  = nf_rdata;
    if (ctl_i.ld.e1)  r_d.e1  = ns_rdata;
    if (ctl_i.ld.f01) r_d.f01 = nf_rdata;
    if (ctl_i.ld.f11) r_d.f11 = nf_rdata;
    if (ctl_i.ld.v12) r_d.v12 = cv_rdata;
    if (ctl_i.ld.v02) r_d.v02 = cv_rdata;
    if (ctl_i.ld.t1)  r_d.t1  = ns_rdata;
    if (ctl_i.ld.t2)  r_d.t2  = ns_rdata;
    if (ctl_i.ld.sx)  r_d.sx  = ns_rdata;
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  tmef_ram #(.WIDTH(VERT_W), .DEPTH(ENTRIES)) u_cv_ram (
    .clk_i   (clk_i),
    .re_i    (cv_re),
    .we_i    (cv_we),
    .addr_i  (cv_addr),
    .wdata_i (cv_data[VERT_W-1:0]),
    .rdata_o (cv_rdata)
  );

  tmef_ram #(.WIDTH(NBR_W), .DEPTH(ENTRIES)) u_nf_ram (
    .clk_i   (clk_i),
    .re_i    (nf_re),
    .we_i    (nf_we),
    .addr_i  (nf_addr),
    .wdata_i (nf_data),
    .rdata_o (nf_rdata)
  );

  tmef_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_ns_ram (
    .clk_i   (clk_i),
    .re_i    (ns_re),
    .we_i    (ns_we),
    .addr_i  (ns_addr),
    .wdata_i (ns_data[SLOT_W-1:0]),
    .rdata_o (ns_rdata)
  );

  assign boundary_o    = !face_ok(r_q.f1, MAX_FACES) || (r_q.e1 == SLOT_NONE);
  assign rd_vertex_o   = cv_rdata;
  assign rd_neighbor_o = $signed(nf_rdata);
  assign rd_slot_o     = (ns_rdata == SLOT_NONE) ? {NSLOT_W{1'b1}} : {1'b0, ns_rdata};
endmodule

[sv/triangle_mesh_edge_flip.sv]
// top level of the triangle mesh edge flip block: request/response channels,
// result register, sequencer and datapath; depends on tmef_pkg, the channel
// interfaces, tmef_seq and tmef_dp
//
// - req_i carries one word per request: write an entry, read an entry, or
//   flip the edge given by face and edge_req. rsp_o returns exactly one word
//   per request, in request order.
// - entries sit at 3 * face + slot in three single-port tables; a flip runs a
//   short microprogram, at most one access per table per cycle.
// - one request at a time: req_i.ready is high only in the idle step, so a new
//   request is taken only after the previous one has left its completion step;
//   a full flip runs longest, set by the chain of dependent neighbor-face and
//   neighbor-slot accesses
// - the result word is loaded into the result register from the completion step
// - when rsp_o stalls with a word waiting, one more request is still taken and
//   runs up to its completion step, where it holds; req_i.ready then stays low
//   until the waiting word leaves and the parked one takes its place
// - reset clears the sequencer and result valid only; table contents are
//   undefined until written
module triangle_mesh_edge_flip #(
  parameter int unsigned MAX_FACES = tmef_pkg::MAX_FACES_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  tmef_req_if.sink   req_i,
  tmef_rsp_if.source rsp_o
);
  import tmef_pkg::*;

  ctl_t    ctl;
  seq_in_t seq_in;
  logic    accept;
  logic    out_free;
  logic    out_load;
  logic    boundary;

  logic [VERT_W-1:0]         rd_vertex;
  logic signed [NBR_W-1:0]   rd_neighbor;
  logic signed [NSLOT_W-1:0] rd_slot;

  // result register
  logic                      valid_q, valid_d;
  logic [VERT_W-1:0]         vertex_q;
  logic signed [NBR_W-1:0]   neighbor_q;
  logic signed [NSLOT_W-1:0] nslot_q;
  status_e                   status_q;

  // the idle step is the only one that waits for a request
  assign req_i.ready = (ctl.jmp == J_DISPATCH);
  assign accept      = req_i.valid && req_i.ready;

  // result register frees up when empty or being drained this cycle
  assign out_free = !valid_q || rsp_o.ready;
  assign out_load = ctl.done && out_free;

  always_comb begin
    seq_in.accept   = accept;
    seq_in.req_type = req_i.req_type;
    // slot code 3 or a face past the table end
    seq_in.addr_bad = (req_i.edge_req == SLOT_NONE) || (32'(req_i.face) >= MAX_FACES);
    seq_in.boundary = boundary;
    seq_in.out_free = out_free;
  end

  tmef_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seq_i  (seq_in),
    .ctl_o  (ctl)
  );

  tmef_dp #(.MAX_FACES(MAX_FACES)) u_dp (
    .clk_i           (clk_i),
    .ctl_i           (ctl),
    .capture_i       (accept),
    .face_i          (req_i.face),
    .edge_i          (req_i.edge_req),
    .vertex_i        (req_i.vertex_in),
    .neighbor_i      (req_i.neighbor_in),
    .neighbor_edge_i (req_i.neighbor_edge_in),
    .boundary_o      (boundary),
    .rd_vertex_o     (rd_vertex),
    .rd_neighbor_o   (rd_neighbor),
    .rd_slot_o       (rd_slot)
  );

  always_comb begin
    valid_d = valid_q;
    if (out_load) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // data fields are zero except on a read
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      vertex_q   <= ctl.rd_out ? rd_vertex : '0;
      neighbor_q <= ctl.rd_out ? rd_neighbor : '0;
      nslot_q    <= ctl.rd_out ? rd_slot : '0;
      status_q   <= ctl.status;
    end
  end

  assign rsp_o.valid             = valid_q;
  assign rsp_o.vertex_out        = vertex_q;
  assign rsp_o.neighbor_out      = neighbor_q;
  assign rsp_o.neighbor_edge_out = nslot_q;
  assign rsp_o.status            = status_q;

  // a request leaves the idle step at once
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready still high after a request was taken");

  // a result word only appears from a completion step
  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(ctl.done))
    else $error("result word loaded outside a completion step");

  // a blocked completion waits with its status intact
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.done && !out_free) |=> (ctl.done && $stable(ctl.status)))
    else $error("completion step left while the result register was full");
endmodule

[tb/triangle_mesh_edge_flip_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for triangle_mesh_edge_flip: directed entry, flip and boundary
// tests, then random meshes with flips, plus an output hold; needs tmef_pkg and the
// tmef_req_if / tmef_rsp_if channel interfaces
module triangle_mesh_edge_flip_test;
  import tmef_pkg::*;

  // request codes and slot values the package does not name
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN    = 2'd3;
  localparam logic [SLOT_W-1:0]  SLOT_BAD       = 2'd3;
  localparam logic [NSLOT_W-1:0] NSLOT_NONE_OUT = '1;

  localparam int unsigned ENTRIES = 3 * MAX_FACES_DEF;

  // slowest honest stretch without any word moving is the deliberate output hold
  // below (OUT_HOLD); gaps, full flips and other receiver stalls are shorter
  localparam int unsigned OUT_HOLD       = 160;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned TAIL_CYCLES    = 24;

  // one request word as the sender sees it
  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [FACE_W-1:0]  face;
    logic [SLOT_W-1:0]  slot;
    logic [VERT_W-1:0]  vtx;
    logic [NBR_W-1:0]   nbr;
    logic [NSLOT_W-1:0] nslot;
  } mesh_cmd_t;

  // one result word
  typedef struct {
    logic [VERT_W-1:0]   vtx;
    logic [NBR_W-1:0]    nbr;
    logic [NSLOT_W-1:0]  nslot;
    logic [STATUS_W-1:0] status;
  } mesh_ans_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  tmef_req_if req_ch ();
  tmef_rsp_if rsp_ch ();

  triangle_mesh_edge_flip dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // mirror of the mesh tables; the *_set flags remember which entries hold data,
  // since the block returns junk for entries never written
  // ---------------------------------------------------------------------------
  logic [VERT_W-1:0] cv_tab [ENTRIES];
  logic [NBR_W-1:0]  nf_tab [ENTRIES];
  logic [SLOT_W-1:0] ns_tab [ENTRIES];
  bit                cv_set [ENTRIES];
  bit                nf_set [ENTRIES];
  bit                ns_set [ENTRIES];

  // planned adjacency while a random mesh is being laid down
  int link_face [ENTRIES];
  int link_slot [ENTRIES];

  int unsigned mesh_faces [$];
  mesh_ans_t   pending_answers [$];

  int unsigned n_write, n_read, n_flip_ok, n_flip_bnd, n_bad_slot, n_unknown;
  int unsigned n_checked, n_errors;

  bit          req_gaps_on = 1'b1;
  bit          rsp_gaps_on = 1'b1;
  int unsigned rsp_stall_len;

  function automatic int unsigned entry_of(int unsigned f, int unsigned e);
    return 3 * f + e;
  endfunction

  function automatic bit is_real_face(int f);
    return f >= 0 && f < int'(MAX_FACES_DEF);
  endfunction

  function automatic int nbr_of(int unsigned f, int unsigned e);
    return int'($signed(nf_tab[entry_of(f, e)]));
  endfunction

  function automatic void put_vertex(int unsigned idx, logic [VERT_W-1:0] v);
    cv_tab[idx] = v;
    cv_set[idx] = 1'b1;
  endfunction

  function automatic void put_face(int unsigned idx, int f);
    nf_tab[idx] = f[NBR_W-1:0];
    nf_set[idx] = 1'b1;
  endfunction

  function automatic void put_slot(int unsigned idx, logic [SLOT_W-1:0] s);
    ns_tab[idx] = s;
    ns_set[idx] = 1'b1;
  endfunction

  // flip of the edge in slot e0 of face f0, in the exact order of reads and writes
  // the block must honor when faces alias
  function automatic status_e flip_in_model(int unsigned f0, int unsigned e0);
    int          f1s, f01, f11;
    int unsigned f1, e1, e01, e02, e11, e12, s;
    f1s = nbr_of(f0, e0);
    e1  = ns_tab[entry_of(f0, e0)];
    if (!is_real_face(f1s) || e1 == SLOT_NONE) return ST_BOUNDARY;
    f1  = f1s;
    e01 = (e0 + 1) % 3;
    e02 = (e0 + 2) % 3;
    e11 = (e1 + 1) % 3;
    e12 = (e1 + 2) % 3;
    f01 = nbr_of(f0, e01);
    f11 = nbr_of(f1, e11);

    put_vertex(entry_of(f0, e01), cv_tab[entry_of(f1, e12)]);
    put_vertex(entry_of(f1, e11), cv_tab[entry_of(f0, e02)]);

    put_face(entry_of(f0, e0), f11);
    put_face(entry_of(f0, e01), f1);
    put_face(entry_of(f1, e1), f01);
    put_face(entry_of(f1, e11), f0);
    // outer neighbors point back at the face that now borders them
    if (is_real_face(f11)) begin
      s = ns_tab[entry_of(f1, e11)];
      if (s != SLOT_NONE) put_face(entry_of(f11, s), f0);
    end
    if (is_real_face(f01)) begin
      s = ns_tab[entry_of(f0, e01)];
      if (s != SLOT_NONE) put_face(entry_of(f01, s), f1);
    end

    put_slot(entry_of(f0, e0), ns_tab[entry_of(f1, e11)]);
    put_slot(entry_of(f1, e1), ns_tab[entry_of(f0, e01)]);
    put_slot(entry_of(f0, e01), e11[SLOT_W-1:0]);
    put_slot(entry_of(f1, e11), e01[SLOT_W-1:0]);

    if (is_real_face(f11)) begin
      s = ns_tab[entry_of(f0, e0)];
      if (s != SLOT_NONE) put_slot(entry_of(f11, s), e0[SLOT_W-1:0]);
    end
    if (is_real_face(f01)) begin
      s = ns_tab[entry_of(f1, e1)];
      if (s != SLOT_NONE) put_slot(entry_of(f01, s), e1[SLOT_W-1:0]);
    end
    return ST_OK;
  endfunction

  // applies one accepted request to the mirror and returns the word it must produce
  function automatic mesh_ans_t apply_to_mesh(mesh_cmd_t c);
    mesh_ans_t   a;
    int unsigned idx;
    a = '{default: '0};
    if (c.kind == REQ_UNKNOWN) begin
      n_unknown++;
      return a;
    end
    if (c.slot == SLOT_BAD) begin
      n_bad_slot++;
      a.status = ST_INVALID;
      return a;
    end
    // the face field is 10 bits, so it never leaves the tables
    idx = entry_of(c.face, c.slot);
    case (c.kind)
      REQ_WRITE: begin
        n_write++;
        put_vertex(idx, c.vtx);
        put_face(idx, int'($signed(c.nbr)));
        put_slot(idx, (c.nslot <= 3'd2) ? c.nslot[SLOT_W-1:0] : SLOT_NONE);
      end
      REQ_READ: begin
        n_read++;
        a.vtx   = cv_tab[idx];
        a.nbr   = nf_tab[idx];
        a.nslot = (ns_tab[idx] == SLOT_NONE) ? NSLOT_NONE_OUT : {1'b0, ns_tab[idx]};
      end
      default: begin
        a.status = flip_in_model(c.face, c.slot);
        if (a.status == ST_OK) n_flip_ok++;
        else n_flip_bnd++;
      end
    endcase
    return a;
  endfunction

  function automatic bit face_loaded(int f);
    if (!is_real_face(f)) return 1'b0;
    for (int e = 0; e < 3; e++) begin
      if (!(cv_set[3 * f + e] && nf_set[3 * f + e] && ns_set[3 * f + e])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // a flip touches every entry of both faces, so both must hold data;
  // a flip turned away at the first lookup only reads its own face
  function automatic bit flip_is_safe(int unsigned f0, int unsigned e0);
    int f1;
    if (!face_loaded(f0)) return 1'b0;
    f1 = nbr_of(f0, e0);
    if (!is_real_face(f1) || ns_tab[entry_of(f0, e0)] == SLOT_NONE) return 1'b1;
    return face_loaded(f1);
  endfunction

  // ---------------------------------------------------------------------------
  // request words; fields a request ignores carry random bits
  // ---------------------------------------------------------------------------
  function automatic mesh_cmd_t mk_cmd(logic [REQ_W-1:0] kind, int unsigned f, int unsigned e);
    mesh_cmd_t c;
    c.kind  = kind;
    c.face  = f[FACE_W-1:0];
    c.slot  = e[SLOT_W-1:0];
    c.vtx   = VERT_W'($urandom);
    c.nbr   = NBR_W'($urandom);
    c.nslot = NSLOT_W'($urandom);
    return c;
  endfunction

  function automatic mesh_cmd_t mk_write(int unsigned f, int unsigned e, int unsigned v,
                                         int n, int ne);
    mesh_cmd_t c;
    c       = mk_cmd(REQ_WRITE, f, e);
    c.vtx   = v[VERT_W-1:0];
    c.nbr   = n[NBR_W-1:0];
    c.nslot = ne[NSLOT_W-1:0];
    return c;
  endfunction

  // per-word wait of either side, with stretches where waiting is switched off
  function automatic int unsigned pick_gap(inout bit gaps_on);
    if ($urandom_range(0, 39) == 0) gaps_on = !gaps_on;
    return gaps_on ? $urandom_range(0, 13) : 0;
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    // keep the log short when something is badly off
    if (n_errors <= 60) $display("%0t mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // sender: valid is left high after acceptance and only changed when the next
  // word is driven, so each time step sees at most one update of it
  // ---------------------------------------------------------------------------
  task automatic send_req(input mesh_cmd_t c);
    int unsigned gap;
    gap = pick_gap(req_gaps_on);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid            <= 1'b1;
    req_ch.req_type         <= c.kind;
    req_ch.face             <= c.face;
    req_ch.edge_req         <= c.slot;
    req_ch.vertex_in        <= c.vtx;
    req_ch.neighbor_in      <= c.nbr;
    req_ch.neighbor_edge_in <= c.nslot;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_answers.insert(pending_answers.size(), apply_to_mesh(c));
  endtask

  // drops valid right after the last accepted word and waits for all results
  task automatic drain_answers();
    req_ch.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // receiver and result check
  // ---------------------------------------------------------------------------
  initial begin : answer_sink
    mesh_ans_t   got, want;
    int unsigned gap;
    rsp_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      // a requested hold replaces the usual random wait once
      if (rsp_stall_len != 0) begin
        gap           = rsp_stall_len;
        rsp_stall_len = 0;
      end else begin
        gap = pick_gap(rsp_gaps_on);
      end
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
      got.vtx    = rsp_ch.vertex_out;
      got.nbr    = rsp_ch.neighbor_out;
      got.nslot  = rsp_ch.neighbor_edge_out;
      got.status = rsp_ch.status;
      if (pending_answers.size() == 0) begin
        flag_error("result word with no request waiting for it");
      end else begin
        want = pending_answers.pop_front();
        n_checked++;
        if (got.vtx !== want.vtx)
          flag_error($sformatf("word %0d vertex_out %0d, want %0d",
                               n_checked, got.vtx, want.vtx));
        if (got.nbr !== want.nbr)
          flag_error($sformatf("word %0d neighbor_out %0d, want %0d",
                               n_checked, $signed(got.nbr), $signed(want.nbr)));
        if (got.nslot !== want.nslot)
          flag_error($sformatf("word %0d neighbor_edge_out %0d, want %0d",
                               n_checked, $signed(got.nslot), $signed(want.nslot)));
        if (got.status !== want.status)
          flag_error($sformatf("word %0d status %0d, want %0d",
                               n_checked, got.status, want.status));
      end
    end
  end

  // watchdog: ends the run when no word moves on either channel for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("triangle_mesh_edge_flip_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------------

  // single entries at the field extremes, the bad slot on every request, and
  // the unknown request code
  task automatic test_entry_access();
    send_req(mk_write(0, 0, 1023, -1, -1));
    send_req(mk_cmd(REQ_READ, 0, 0));
    send_req(mk_write(MAX_FACES_DEF - 1, 2, 0, 1023, 2));
    send_req(mk_cmd(REQ_READ, MAX_FACES_DEF - 1, 2));
    // alternating bits; a neighbor slot of -4 is stored as no slot
    send_req(mk_write(512, 1, 'h2AA, -683, -4));
    send_req(mk_cmd(REQ_READ, 512, 1));
    // a write to the bad slot must leave face 0 alone
    send_req(mk_write(0, SLOT_BAD, 5, 6, 1));
    send_req(mk_cmd(REQ_READ, 0, SLOT_BAD));
    send_req(mk_cmd(REQ_FLIP, 7, SLOT_BAD));
    send_req(mk_cmd(REQ_UNKNOWN, 0, 0));
    send_req(mk_cmd(REQ_READ, 0, 0));
  endtask

  // two faces sharing edge slot 0; face 3 has face 0 as outer neighbor, so its
  // back link gets rewritten, while face 2's outer edge is a boundary
  task automatic test_quad_flip();
    send_req(mk_write(2, 0, 10, 3, 0));
    send_req(mk_write(2, 1, 11, -1, -1));
    send_req(mk_write(2, 2, 12, -1, -1));
    send_req(mk_write(3, 0, 13, 2, 0));
    send_req(mk_write(3, 1, 14, 0, 0));
    send_req(mk_write(3, 2, 15, -1, -1));
    send_req(mk_cmd(REQ_FLIP, 2, 0));
    send_req(mk_cmd(REQ_READ, 2, 0));
    send_req(mk_cmd(REQ_READ, 3, 1));
    send_req(mk_cmd(REQ_READ, 0, 0));
  endtask

  // flips refused for a missing neighbor slot, for a negative neighbor and for
  // a boundary edge; the last one goes through with an outer neighbor that has
  // no slot, so its back link stays as it is
  task automatic test_boundary_flip();
    send_req(mk_write(4, 0, 20, 700, -1));
    send_req(mk_write(4, 1, 21, -1024, 1));
    send_req(mk_write(4, 2, 22, 2, 2));
    send_req(mk_cmd(REQ_FLIP, 4, 0));
    send_req(mk_cmd(REQ_FLIP, 4, 1));
    send_req(mk_cmd(REQ_FLIP, 2, 2));
    send_req(mk_cmd(REQ_FLIP, 4, 2));
  endtask

  // lays down a random mesh: every slot of the chosen faces is paired with a slot
  // of another face, both sides pointing at each other, or left as a boundary
  task automatic build_mesh(input int unsigned nfaces, input bit with_ends);
    bit          used [MAX_FACES_DEF];
    int unsigned slots [$];
    int unsigned f, a, b, j, tmp;
    mesh_faces.delete();
    if (with_ends) begin
      mesh_faces.insert(mesh_faces.size(), 0);
      mesh_faces.insert(mesh_faces.size(), MAX_FACES_DEF - 1);
      used[0]                 = 1'b1;
      used[MAX_FACES_DEF - 1] = 1'b1;
    end
    while (mesh_faces.size() < nfaces) begin
      f = $urandom_range(0, MAX_FACES_DEF - 1);
      if (!used[f]) begin
        used[f] = 1'b1;
        mesh_faces.insert(mesh_faces.size(), f);
      end
    end
    foreach (mesh_faces[i]) begin
      for (int e = 0; e < 3; e++) begin
        slots.insert(slots.size(), 3 * mesh_faces[i] + e);
        link_face[3 * mesh_faces[i] + e] = -1;
        link_slot[3 * mesh_faces[i] + e] = -1;
      end
    end
    for (int i = slots.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = slots[i];
      slots[i] = slots[j];
      slots[j] = tmp;
    end
    // two slots of one face never share an edge; some pairs stay open as boundary
    for (int i = 0; i + 1 < slots.size(); i += 2) begin
      a = slots[i];
      b = slots[i + 1];
      if (a / 3 != b / 3 && $urandom_range(0, 7) != 0) begin
        link_face[a] = b / 3;
        link_slot[a] = b % 3;
        link_face[b] = a / 3;
        link_slot[b] = a % 3;
      end
    end
    foreach (slots[i])
      send_req(mk_write(slots[i] / 3, slots[i] % 3, $urandom_range(0, 1023),
                        link_face[slots[i]], link_slot[slots[i]]));
  endtask

  // mostly flips and reads on the current mesh, with some corrupting writes,
  // bad slots and unknown requests mixed in
  task automatic run_mesh_ops(input int unsigned count);
    int unsigned f, e, roll;
    int          n;
    repeat (count) begin
      f    = mesh_faces[$urandom_range(0, mesh_faces.size() - 1)];
      e    = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // a neighbor that was never laid down would make the flip read junk
        if (flip_is_safe(f, e)) send_req(mk_cmd(REQ_FLIP, f, e));
        else send_req(mk_cmd(REQ_READ, f, e));
      end else if (roll < 78) begin
        send_req(mk_cmd(REQ_READ, f, e));
      end else if (roll < 88) begin
        // broken adjacency: half into the mesh, half any 11-bit value
        if ($urandom_range(0, 1) == 0)
          n = mesh_faces[$urandom_range(0, mesh_faces.size() - 1)];
        else
          n = int'($signed(NBR_W'($urandom)));
        send_req(mk_write(f, e, $urandom_range(0, 1023), n, $urandom_range(0, 7)));
      end else if (roll < 96) begin
        send_req(mk_cmd(REQ_W'($urandom_range(REQ_WRITE, REQ_FLIP)),
                        $urandom_range(0, MAX_FACES_DEF - 1), SLOT_BAD));
      end else begin
        send_req(mk_cmd(REQ_UNKNOWN, $urandom_range(0, MAX_FACES_DEF - 1),
                        $urandom_range(0, 3)));
      end
    end
  endtask

  task automatic test_random_mesh(input int unsigned rounds, input bit with_ends);
    for (int r = 0; r < rounds; r++) begin
      build_mesh($urandom_range(12, 60), with_ends && r == 0);
      run_mesh_ops(290);
    end
  endtask

  // the receiver holds off for a long stretch while requests keep coming, so the
  // result register fills, the sequencer parks and request ready drops
  task automatic test_output_stall();
    drain_answers();
    rsp_stall_len = OUT_HOLD;
    req_gaps_on   = 1'b0;
    run_mesh_ops(30);
    drain_answers();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    req_ch.valid            <= 1'b0;
    req_ch.req_type         <= '0;
    req_ch.face             <= '0;
    req_ch.edge_req         <= '0;
    req_ch.vertex_in        <= '0;
    req_ch.neighbor_in      <= '0;
    req_ch.neighbor_edge_in <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_entry_access();
    test_quad_flip();
    test_boundary_flip();
    test_random_mesh(2, 1'b1);
    test_output_stall();
    test_random_mesh(2, 1'b0);

    drain_answers();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d writes, %0d reads, %0d flips done, %0d flips refused at a boundary",
             n_write, n_read, n_flip_ok, n_flip_bnd);
    $display("plus %0d bad-slot and %0d unknown requests; %0d results compared, %0d mismatches",
             n_bad_slot, n_unknown, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("triangle_mesh_edge_flip_test: done, clean");
    end else begin
      $display("triangle_mesh_edge_flip_test: done, errors");
    end
    $finish;
  end

endmodule
